// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reported by label
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, reported by label
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Register indexes, calibration constants and sequencer states.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RawWidth  = 19;
   localparam int unsigned CsrWidth  = 64;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned CntWidth  = $clog2(DataWidth);

   localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
   localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
   localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
   localparam logic [1:0] REG_OSS         = 2'd3;

   localparam logic [DataWidth-1:0] B6_OFFSET   = 32'd4000;
   localparam logic [DataWidth-1:0] B4_OFFSET   = 32'd32768;
   localparam logic [DataWidth-1:0] PRESS_SCALE = 32'd50000;
   localparam logic [DataWidth-1:0] SIGN_BIT    = 32'h8000_0000;
   localparam logic [DataWidth-1:0] POLY_C1     = 32'd3038;
   localparam logic [DataWidth-1:0] POLY_C2     = 32'hFFFF_E343; // -7357
   localparam logic [DataWidth-1:0] POLY_C3     = 32'd3791;

   localparam logic [1:0] OSS_RESET = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_MUL,
      ST_T_DEN,
      ST_T_FIN,
      ST_P_SQ,
      ST_P_X1,
      ST_P_X2,
      ST_P_B3,
      ST_P_X4,
      ST_P_B4,
      ST_P_B7,
      ST_P_DIV,
      ST_P_TT,
      ST_P_C1,
      ST_P_C2,
      ST_P_FIN,
      ST_DIV,
      ST_DONE
   } bsc_state_type;

endpackage

// File: sv/barometric_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit
// Integer calibration of raw temperature and pressure readings, one shared
// 32x32 multiplier and one radix-2 divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_kind, req_raw_reading
//  rsp     | out       | rsp_valid/rsp_stall | rsp_result_kind,
//          |           |                     | rsp_compensated_value,
//          |           |                     | rsp_divide_error
//  csr     | in        | APB psel/penable    | csr_paddr, csr_pwdata, csr_prdata
//
//  A temperature item runs T_MUL, T_DEN, the divider and T_FIN; a pressure
//  item runs P_SQ to P_DIV, the divider, then P_TT to P_FIN. Every item ends
//  in DONE, which loads the result register. A zero divisor skips the
//  divider and the steps after it. One item is worked at a time; req_stall
//  stays high until the result is in the output register, which holds it
//  while rsp_stall is high. Synchronous reset clears control, the calibration
//  registers and the stored B5, and sets the oversampling register to OSS_RESET.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [bsc_pkg::RawWidth-1:0]          req_raw_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic signed [bsc_pkg::DataWidth-1:0]  rsp_compensated_value,
   output logic                                  rsp_divide_error,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bsc_pkg::AddrWidth-1:0]         csr_paddr,
   input  logic [bsc_pkg::CsrWidth-1:0]          csr_pwdata,
   output logic [bsc_pkg::CsrWidth-1:0]          csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned W = bsc_pkg::DataWidth;

   // configuration registers
   logic [63:0] temp_cal_ff, press_cal_a_ff;
   logic [31:0] press_cal_b_ff;
   logic [1:0]  oss_ff;

   // sequencer and datapath registers
   bsc_pkg::bsc_state_type state_ff, state_in;
   logic                           kind_ff, kind_in;
   logic [bsc_pkg::RawWidth-1:0]   raw_ff, raw_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] b3_ff, b3_in;
   logic [W-1:0] p_ff, p_in;
   logic [W-1:0] last_b5_ff, last_b5_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quot_ff, quot_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic         neg_ff, neg_in;
   logic         dbl_ff, dbl_in;
   logic [bsc_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [W-1:0] val_ff, val_in;
   logic         err_ff, err_in;

   // output register
   logic         out_valid_ff, out_valid_in;
   logic         out_kind_ff, out_kind_in;
   logic [W-1:0] out_val_ff, out_val_in;
   logic         out_err_ff, out_err_in;

   // shared multiplier operands
   logic [W-1:0] mul_a, mul_b;

   // coefficient fields
   logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2, b6;

   logic accept, out_free, csr_write;
   logic [W:0] rem_sh;

   // scratch values for the datapath block
   logic [W-1:0] x1, den, mcs, x3, qv, b5, tt;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign ac5 = {16'd0, temp_cal_ff[63:48]};
   assign ac6 = {16'd0, temp_cal_ff[47:32]};
   assign mc  = {{16{temp_cal_ff[31]}}, temp_cal_ff[31:16]};
   assign md  = {{16{temp_cal_ff[15]}}, temp_cal_ff[15:0]};
   assign ac1 = {{16{press_cal_a_ff[63]}}, press_cal_a_ff[63:48]};
   assign ac2 = {{16{press_cal_a_ff[47]}}, press_cal_a_ff[47:32]};
   assign ac3 = {{16{press_cal_a_ff[31]}}, press_cal_a_ff[31:16]};
   assign ac4 = {16'd0, press_cal_a_ff[15:0]};
   assign b1  = {{16{press_cal_b_ff[31]}}, press_cal_b_ff[31:16]};
   assign b2  = {{16{press_cal_b_ff[15]}}, press_cal_b_ff[15:0]};
   assign b6  = last_b5_ff - bsc_pkg::B6_OFFSET;

   // one divider step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff, quot_ff[W-1]};

   // low word of the product; signedness does not change it
   assign prod_in = mul_a * mul_b;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[4:3])
         bsc_pkg::REG_TEMP_CAL:    csr_prdata = temp_cal_ff;
         bsc_pkg::REG_PRESS_CAL_A: csr_prdata = press_cal_a_ff;
         bsc_pkg::REG_PRESS_CAL_B: csr_prdata = {32'd0, press_cal_b_ff};
         bsc_pkg::REG_OSS:         csr_prdata = {62'd0, oss_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         oss_ff         <= bsc_pkg::OSS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[4:3])
            bsc_pkg::REG_TEMP_CAL:    temp_cal_ff    <= csr_pwdata;
            bsc_pkg::REG_PRESS_CAL_A: press_cal_a_ff <= csr_pwdata;
            bsc_pkg::REG_PRESS_CAL_B: press_cal_b_ff <= csr_pwdata[31:0];
            bsc_pkg::REG_OSS:         oss_ff         <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (accept) state_in = req_kind ? bsc_pkg::ST_P_SQ : bsc_pkg::ST_T_MUL;
         end
         bsc_pkg::ST_T_MUL: state_in = bsc_pkg::ST_T_DEN;
         bsc_pkg::ST_T_DEN: begin
            // zero denominator: skip the divider
            state_in = (den == '0) ? bsc_pkg::ST_DONE : bsc_pkg::ST_DIV;
         end
         bsc_pkg::ST_T_FIN: state_in = bsc_pkg::ST_DONE;
         bsc_pkg::ST_P_SQ:  state_in = bsc_pkg::ST_P_X1;
         bsc_pkg::ST_P_X1:  state_in = bsc_pkg::ST_P_X2;
         bsc_pkg::ST_P_X2:  state_in = bsc_pkg::ST_P_B3;
         bsc_pkg::ST_P_B3:  state_in = bsc_pkg::ST_P_X4;
         bsc_pkg::ST_P_X4:  state_in = bsc_pkg::ST_P_B4;
         bsc_pkg::ST_P_B4:  state_in = bsc_pkg::ST_P_B7;
         bsc_pkg::ST_P_B7:  state_in = bsc_pkg::ST_P_DIV;
         bsc_pkg::ST_P_DIV: begin
            state_in = (dvs_ff == '0) ? bsc_pkg::ST_DONE : bsc_pkg::ST_DIV;
         end
         bsc_pkg::ST_DIV: begin
            if (cnt_ff == '1) state_in = kind_ff ? bsc_pkg::ST_P_TT : bsc_pkg::ST_T_FIN;
         end
         bsc_pkg::ST_P_TT:  state_in = bsc_pkg::ST_P_C1;
         bsc_pkg::ST_P_C1:  state_in = bsc_pkg::ST_P_C2;
         bsc_pkg::ST_P_C2:  state_in = bsc_pkg::ST_P_FIN;
         bsc_pkg::ST_P_FIN: state_in = bsc_pkg::ST_DONE;
         bsc_pkg::ST_DONE: begin
            if (out_free) state_in = bsc_pkg::ST_IDLE;
         end
         default: state_in = bsc_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      x1  = $unsigned($signed(prod_ff) >>> 15);
      den = x1 + md;
      mcs = mc << 11;
      x3  = '0;
      qv  = neg_ff ? (32'd0 - quot_ff) : quot_ff;
      b5  = acc_ff + qv;
      tt  = '0;

      req_stall  = (state_ff != bsc_pkg::ST_IDLE);
      kind_in    = kind_ff;
      raw_in     = raw_ff;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      b3_in      = b3_ff;
      p_in       = p_ff;
      last_b5_in = last_b5_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      dvs_in     = dvs_ff;
      neg_in     = neg_ff;
      dbl_in     = dbl_ff;
      cnt_in     = cnt_ff;
      val_in     = val_ff;
      err_in     = err_ff;
      mul_a      = '0;
      mul_b      = '0;

      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_val_in   = out_val_ff;
      out_err_in   = out_err_ff;

      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               raw_in  = req_raw_reading;
               err_in  = 1'b0;
               val_in  = '0;
            end
         end
         bsc_pkg::ST_T_MUL: begin
            mul_a = {{(W-bsc_pkg::RawWidth){1'b0}}, raw_ff} - ac6;
            mul_b = ac5;
         end
         bsc_pkg::ST_T_DEN: begin
            // hold x1 in acc for the final B5 sum, set up the signed divide
            acc_in  = x1;
            err_in  = (den == '0);
            quot_in = mcs[W-1] ? (32'd0 - mcs) : mcs;
            dvs_in  = den[W-1] ? (32'd0 - den) : den;
            neg_in  = mcs[W-1] ^ den[W-1];
            rem_in  = '0;
            cnt_in  = '0;
         end
         bsc_pkg::ST_T_FIN: begin
            last_b5_in = b5;
            val_in     = $unsigned($signed(b5 + 32'd8) >>> 4);
         end
         bsc_pkg::ST_P_SQ: begin
            mul_a = b6;
            mul_b = b6;
         end
         bsc_pkg::ST_P_X1: begin
            sq_in = $unsigned($signed(prod_ff) >>> 12);
            mul_a = b2;
            mul_b = sq_in;
         end
         bsc_pkg::ST_P_X2: begin
            acc_in = $unsigned($signed(prod_ff) >>> 11);
            mul_a  = ac2;
            mul_b  = b6;
         end
         bsc_pkg::ST_P_B3: begin
            x3    = acc_ff + $unsigned($signed(prod_ff) >>> 11);
            b3_in = $unsigned($signed(((ac1 << 2) + x3) << oss_ff) + 32'sd2 >>> 2);
            mul_a = ac3;
            mul_b = b6;
         end
         bsc_pkg::ST_P_X4: begin
            acc_in = $unsigned($signed(prod_ff) >>> 13);
            mul_a  = b1;
            mul_b  = sq_ff;
         end
         bsc_pkg::ST_P_B4: begin
            x3    = acc_ff + $unsigned($signed(prod_ff) >>> 16) + 32'd2;
            x3    = $unsigned($signed(x3) >>> 2);
            mul_a = ac4;
            mul_b = x3 + bsc_pkg::B4_OFFSET;
         end
         bsc_pkg::ST_P_B7: begin
            dvs_in = prod_ff >> 15;
            mul_a  = {{(W-bsc_pkg::RawWidth){1'b0}}, raw_ff} - b3_ff;
            mul_b  = bsc_pkg::PRESS_SCALE >> oss_ff;
         end
         bsc_pkg::ST_P_DIV: begin
            // B7 below the sign bit doubles before the divide, else after
            err_in  = (dvs_ff == '0);
            dbl_in  = (prod_ff >= bsc_pkg::SIGN_BIT);
            quot_in = (prod_ff < bsc_pkg::SIGN_BIT) ? (prod_ff << 1) : prod_ff;
            neg_in  = 1'b0;
            rem_in  = '0;
            cnt_in  = '0;
         end
         bsc_pkg::ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in  = W'(rem_sh - {1'b0, dvs_ff});
               quot_in = {quot_ff[W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[W-1:0];
               quot_in = {quot_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         bsc_pkg::ST_P_TT: begin
            p_in  = dbl_ff ? (quot_ff << 1) : quot_ff;
            tt    = $unsigned($signed(p_in) >>> 8);
            mul_a = tt;
            mul_b = tt;
         end
         bsc_pkg::ST_P_C1: begin
            mul_a = prod_ff;
            mul_b = bsc_pkg::POLY_C1;
         end
         bsc_pkg::ST_P_C2: begin
            acc_in = $unsigned($signed(prod_ff) >>> 16);
            mul_a  = bsc_pkg::POLY_C2;
            mul_b  = p_ff;
         end
         bsc_pkg::ST_P_FIN: begin
            x3     = acc_ff + $unsigned($signed(prod_ff) >>> 16) + bsc_pkg::POLY_C3;
            val_in = p_ff + $unsigned($signed(x3) >>> 4);
         end
         bsc_pkg::ST_DONE: begin
            // load the result register once it is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               out_val_in   = err_ff ? '0 : val_ff;
               out_err_in   = err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         last_b5_ff   <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         last_b5_ff   <= last_b5_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      raw_ff      <= raw_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      b3_ff       <= b3_in;
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      dbl_ff      <= dbl_in;
      val_ff      <= val_in;
      err_ff      <= err_in;
      out_kind_ff <= out_kind_in;
      out_val_ff  <= out_val_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_result_kind       = out_kind_ff;
   assign rsp_compensated_value = $signed(out_val_ff);
   assign rsp_divide_error      = out_err_ff;

endmodule

// File: sv/bsc_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Port-level properties of the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_kind,
   input logic [bsc_pkg::RawWidth-1:0]          req_raw_reading,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_result_kind,
   input logic signed [bsc_pkg::DataWidth-1:0]  rsp_compensated_value,
   input logic                                  rsp_divide_error,
   input logic                                  csr_psel,
   input logic                                  csr_penable,
   input logic                                  csr_pwrite,
   input logic [bsc_pkg::AddrWidth-1:0]         csr_paddr,
   input logic [bsc_pkg::CsrWidth-1:0]          csr_pwdata,
   input logic [bsc_pkg::CsrWidth-1:0]          csr_prdata,
   input logic                                  csr_pready
);

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // an accepted item keeps the unit busy on the next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a divide error always carries a zero value
   `ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_divide_error, rsp_compensated_value == 0)

endmodule

bind barometric_sensor_compensation_unit bsc_checker u_bsc_checker (.*);

// File: test/tb_barometric_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometric compensation unit testbench
// Drives raw temperature and pressure readings through the unit under a range
// of calibration settings. An in-bench predictor computes each compensated
// value with 32-bit wrap. A result monitor compares every result, field by
// field, in order. Sender and receiver idle at random, and one long receiver
// hold-off fills the unit.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 60;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        div_err;
   } comp_result_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_kind;
   logic [bsc_pkg::RawWidth-1:0]          req_raw_reading;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_result_kind;
   logic signed [bsc_pkg::DataWidth-1:0]  rsp_compensated_value;
   logic                                  rsp_divide_error;
   logic                                  csr_psel;
   logic                                  csr_penable;
   logic                                  csr_pwrite;
   logic [bsc_pkg::AddrWidth-1:0]         csr_paddr;
   logic [bsc_pkg::CsrWidth-1:0]          csr_pwdata;
   logic [bsc_pkg::CsrWidth-1:0]          csr_prdata;
   logic                                  csr_pready;

   // predictor copy of the calibration and the stored B5
   logic [63:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [31:0] cal_press_b;
   logic [1:0]  cal_oss;
   logic [31:0] b5_store;

   comp_result_type pending_results[$];
   int              fail_count;
   int              cycle_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              recv_hold_left;

   barometric_sensor_compensation_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------------
   function automatic logic [31:0] asr(logic [31:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [31:0] sext16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // truncating signed divide; the most negative word over -1 wraps to itself
   function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // compute one result and advance the stored B5
   function automatic comp_result_type compensate(logic kind, logic [18:0] raw);
      comp_result_type r;
      logic [31:0]  raw32, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0]  x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
      raw32 = {13'd0, raw};
      r.kind = kind;
      r.value = '0;
      r.div_err = 1'b0;
      if (kind == 1'b0) begin
         ac5 = {16'd0, cal_temp[63:48]};
         ac6 = {16'd0, cal_temp[47:32]};
         mc  = sext16(cal_temp[31:16]);
         md  = sext16(cal_temp[15:0]);
         x1  = asr((raw32 - ac6) * ac5, 15);
         den = x1 + md;
         if (den == '0) begin
            r.div_err = 1'b1;
         end else begin
            b5 = x1 + trunc_div(mc << 11, den);
            b5_store = b5;
            r.value = asr(b5 + 32'd8, 4);
         end
      end else begin
         ac1 = sext16(cal_press_a[63:48]);
         ac2 = sext16(cal_press_a[47:32]);
         ac3 = sext16(cal_press_a[31:16]);
         ac4 = {16'd0, cal_press_a[15:0]};
         b1  = sext16(cal_press_b[31:16]);
         b2  = sext16(cal_press_b[15:0]);
         b6  = b5_store - bsc_pkg::B6_OFFSET;
         sq  = asr(b6 * b6, 12);
         x1  = asr(b2 * sq, 11);
         x2  = asr(ac2 * b6, 11);
         x3  = x1 + x2;
         b3  = asr(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
         x1  = asr(ac3 * b6, 13);
         x2  = asr(b1 * sq, 16);
         x3  = asr(x1 + x2 + 32'd2, 2);
         b4  = (ac4 * (x3 + bsc_pkg::B4_OFFSET)) >> 15;
         b7  = (raw32 - b3) * (bsc_pkg::PRESS_SCALE >> cal_oss);
         if (b4 == '0) begin
            r.div_err = 1'b1;
         end else begin
            if (b7 < bsc_pkg::SIGN_BIT) p = (b7 << 1) / b4;
            else p = (b7 / b4) << 1;
            x1 = asr(p, 8) * asr(p, 8);
            x1 = asr(x1 * bsc_pkg::POLY_C1, 16);
            x2 = asr(bsc_pkg::POLY_C2 * p, 16);
            p  = p + asr(x1 + x2 + bsc_pkg::POLY_C3, 4);
            r.value = p;
         end
      end
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Reset, timeout, receiver stall
   // --------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_raw_reading = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // a requested hold-off wins over the random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (recv_hold_left > 0) begin
         rsp_stall <= 1'b1;
         recv_hold_left = recv_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // --------------------------------------------------------------------------
   // Result monitor: compare against the oldest pending result
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing pending");
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_result_kind !== exp_r.kind) begin
               $error("result_kind: expected %0d, got %0d", exp_r.kind, rsp_result_kind);
               fail_count++;
            end
            if (rsp_compensated_value !== exp_r.value) begin
               $error("compensated_value: expected %0d, got %0d",
                      $signed(exp_r.value), rsp_compensated_value);
               fail_count++;
            end
            if (rsp_divide_error !== exp_r.div_err) begin
               $error("divide_error: expected %0d, got %0d",
                      exp_r.div_err, rsp_divide_error);
               fail_count++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Shared tasks; all start and end just after a rising edge
   // --------------------------------------------------------------------------
   // offer one item, idling first at random; valid stays high after acceptance
   task automatic send_reading(logic kind, logic [18:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_raw_reading <= 19'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_raw_reading <= raw;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(compensate(kind, raw));
   endtask

   // drop valid, wait out every pending result, then let the unit settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         bsc_pkg::REG_TEMP_CAL:    cal_temp = val;
         bsc_pkg::REG_PRESS_CAL_A: cal_press_a = val;
         bsc_pkg::REG_PRESS_CAL_B: cal_press_b = val[31:0];
         default:                  cal_oss = val[1:0];
      endcase
      @(posedge clock);
   endtask

   // typical calibration, optionally jittered around its nominal values
   task automatic load_typical_cal(bit jitter, logic [1:0] oss);
      logic [15:0] j;
      j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
      csr_write(bsc_pkg::REG_TEMP_CAL,
                {16'd32757 - j, 16'd23153 + j, -16'sd8711 + j, 16'd2868 + j});
      csr_write(bsc_pkg::REG_PRESS_CAL_A,
                {16'd408 + j, -16'sd72 - j, -16'sd14383 + j, 16'd32741 - j});
      csr_write(bsc_pkg::REG_PRESS_CAL_B, {16'd6190 + j, 16'd4 + j});
      csr_write(bsc_pkg::REG_OSS, {62'd0, oss});
   endtask

   task automatic load_random_cal();
      csr_write(bsc_pkg::REG_TEMP_CAL, {$urandom, $urandom});
      csr_write(bsc_pkg::REG_PRESS_CAL_A, {$urandom, $urandom});
      csr_write(bsc_pkg::REG_PRESS_CAL_B, {32'd0, $urandom});
      csr_write(bsc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   // reset calibration: every divisor is zero; pressure runs on the reset B5
   task automatic test_reset_defaults();
      send_reading(1'b1, 19'd0);
      send_reading(1'b0, 19'h7FFFF);
      send_reading(1'b1, 19'h7FFFF);
      drain();
   endtask

   task automatic test_typical_cal();
      load_typical_cal(1'b0, 2'd0);
      send_reading(1'b0, 19'd27898);
      send_reading(1'b1, 19'd23843);
      send_reading(1'b0, 19'd0);
      send_reading(1'b1, 19'd0);
      send_reading(1'b0, 19'h7FFFF);
      send_reading(1'b1, 19'h7FFFF);
      drain();
      csr_write(bsc_pkg::REG_OSS, 64'd3);
      send_reading(1'b0, 19'd30000);
      send_reading(1'b1, 19'h5A5A5);
      send_reading(1'b1, 19'h2A5A5);
      drain();
   endtask

   // all-ones and all-zero fields; a temperature divisor of zero keeps the B5
   task automatic test_extreme_cal();
      csr_write(bsc_pkg::REG_TEMP_CAL, '1);
      csr_write(bsc_pkg::REG_PRESS_CAL_A, '1);
      csr_write(bsc_pkg::REG_PRESS_CAL_B, '1);
      send_reading(1'b0, 19'h7FFFF);
      send_reading(1'b1, 19'h7FFFF);
      send_reading(1'b1, 19'd0);
      drain();
      csr_write(bsc_pkg::REG_TEMP_CAL, {16'd0, 16'hFFFF, 16'h8000, 16'd0});
      csr_write(bsc_pkg::REG_PRESS_CAL_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'd0});
      csr_write(bsc_pkg::REG_PRESS_CAL_B, {16'h8000, 16'h7FFF});
      csr_write(bsc_pkg::REG_OSS, 64'd2);
      send_reading(1'b0, 19'd12345);
      send_reading(1'b1, 19'd4000);
      drain();
   endtask

   // mostly temperature-then-pressure pairs, some lone random items
   task automatic test_random_stream(int n_items, int sp, int rp);
      int sent;
      send_idle_pct = sp;
      recv_idle_pct = rp;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            send_reading(1'b0, ($urandom_range(99) < 85) ?
                         19'($urandom_range(0, 65535)) : 19'($urandom));
            send_reading(1'b1, 19'($urandom));
            sent += 2;
         end else begin
            send_reading(1'($urandom), 19'($urandom));
            sent += 1;
         end
         if (sent % 50 < 2 && $urandom_range(1) == 1) begin
            drain();
            if ($urandom_range(1)) load_typical_cal(1'b1, 2'($urandom_range(0, 3)));
            else load_random_cal();
         end
      end
      drain();
   endtask

   // hold the receiver off while items keep coming, then pause until empty
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_typical_cal(1'b1, 2'd1);
      recv_hold_left = 300;
      for (int i = 0; i < 6; i++) send_reading(1'($urandom), 19'($urandom));
      drain();
   endtask

   initial begin
      fail_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold_left = 0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_oss = bsc_pkg::OSS_RESET;
      b5_store = '0;
      @(posedge clock);
      while (reset) @(posedge clock);
      test_reset_defaults();
      test_typical_cal();
      test_extreme_cal();
      test_backpressure();
      load_typical_cal(1'b1, 2'd0);
      test_random_stream(215, 27, 81);
      load_random_cal();
      test_random_stream(215, 81, 27);
      load_typical_cal(1'b1, 2'd3);
      test_random_stream(215, 0, 0);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/bsc_pkg.sv
sv/barometric_sensor_compensation_unit.sv
sv/bsc_checker.sv
test/tb_barometric_sensor_compensation_unit.sv
